/* src/jse_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character constants and output byte sequencing for the JSON string escaper.
package jse_pkg;

	localparam logic [7:0] QUOTE_CHAR     = 8'd34;
	localparam logic [7:0] BACKSLASH_CHAR = 8'd92;
	localparam logic [7:0] NEWLINE_CHAR   = 8'd10;
	localparam logic [7:0] DELETE_CHAR    = 8'd127;
	localparam logic [7:0] LAST_CONTROL   = 8'd31;
	localparam logic [7:0] LETTER_N       = 8'h6e;
	localparam logic [7:0] LETTER_U       = 8'h75;
	localparam logic [7:0] DIGIT_ZERO     = 8'h30;
	localparam logic [7:0] LETTER_A       = 8'h61;

	localparam logic [3:0] UNICODE_ESC_LEN = 4'd6;

	// Depth of the descriptor queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		BODY_NONE,
		BODY_PLAIN,
		BODY_PAIR,
		BODY_UNICODE
	} body_kind_t;

	// One classified item: quotes around it and how its byte is written out.
	typedef struct packed {
		logic       has_open;
		logic       has_close;
		body_kind_t kind;
		logic [7:0] ch;
	} desc_t;

	// Write side of the descriptor queue.
	typedef struct packed {
		logic  push;
		desc_t desc;
	} queue_wr_t;

	// Read side of the descriptor queue.
	typedef struct packed {
		logic  not_empty;
		desc_t desc;
	} queue_rd_t;

	function automatic logic [3:0] body_len(body_kind_t kind);
		logic [3:0] len;
		unique case (kind)
			BODY_NONE:    len = 4'd0;
			BODY_PLAIN:   len = 4'd1;
			BODY_PAIR:    len = 4'd2;
			BODY_UNICODE: len = UNICODE_ESC_LEN;
			default:      len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic logic [3:0] run_len(desc_t d);
		return body_len(d.kind) + {3'd0, d.has_open} + {3'd0, d.has_close};
	endfunction

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		logic [7:0] digit;
		if (n < 4'd10) begin
			digit = DIGIT_ZERO + {4'd0, n};
		end else begin
			digit = LETTER_A + {4'd0, n} - 8'd10;
		end
		return digit;
	endfunction

	function automatic logic [7:0] body_byte(desc_t d, logic [2:0] j);
		logic [7:0] b;
		b = QUOTE_CHAR;
		unique case (d.kind)
			BODY_NONE:  b = QUOTE_CHAR;
			BODY_PLAIN: b = d.ch;
			BODY_PAIR:  b = (j == 3'd0) ? BACKSLASH_CHAR : d.ch;
			BODY_UNICODE: begin
				unique case (j)
					3'd0:    b = BACKSLASH_CHAR;
					3'd1:    b = LETTER_U;
					3'd2:    b = DIGIT_ZERO;
					3'd3:    b = DIGIT_ZERO;
					3'd4:    b = hex_digit(d.ch[7:4]);
					3'd5:    b = hex_digit(d.ch[3:0]);
					default: b = QUOTE_CHAR;
				endcase
			end
			default: b = QUOTE_CHAR;
		endcase
		return b;
	endfunction

	// Byte number idx of the output run that descriptor d gives.
	function automatic logic [7:0] run_byte(desc_t d, logic [2:0] idx);
		logic [2:0] j;
		logic [7:0] b;
		j = idx - {2'd0, d.has_open};
		if (d.has_open && idx == 3'd0) begin
			b = QUOTE_CHAR;
		end else if ({1'b0, j} < body_len(d.kind)) begin
			b = body_byte(d, j);
		end else begin
			b = QUOTE_CHAR;
		end
		return b;
	endfunction

endpackage

/* src/jse_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input items and classifies each one into a descriptor.
module jse_front (
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] text_byte
	input  logic              s_axis_tlast,  // last_of_string
	input  logic [1:0]        s_axis_tuser,  // [0] first_of_string, [1] empty_string
	input  logic              queue_full,
	output jse_pkg::queue_wr_t wr
);

	logic [7:0] c;
	jse_pkg::desc_t d;

	assign c = s_axis_tdata;

	always_comb begin
		d.has_open  = s_axis_tuser[0];
		d.has_close = s_axis_tlast;
		d.ch        = c;
		d.kind      = jse_pkg::BODY_PLAIN;
		if (s_axis_tuser[1]) begin
			// An empty string is just the two quotes.
			d.has_open  = 1'b1;
			d.has_close = 1'b1;
			d.kind      = jse_pkg::BODY_NONE;
		end else if (c == jse_pkg::NEWLINE_CHAR) begin
			d.kind = jse_pkg::BODY_PAIR;
			d.ch   = jse_pkg::LETTER_N;
		end else if (c == jse_pkg::QUOTE_CHAR || c == jse_pkg::BACKSLASH_CHAR) begin
			d.kind = jse_pkg::BODY_PAIR;
		end else if (c <= jse_pkg::LAST_CONTROL || c == jse_pkg::DELETE_CHAR) begin
			d.kind = jse_pkg::BODY_UNICODE;
		end
	end

	assign s_axis_tready = !queue_full;
	assign wr.push       = s_axis_tvalid && !queue_full;
	assign wr.desc       = d;

endmodule

/* src/jse_queue.sv */
`timescale 1ns / 1ps
// Short descriptor queue that decouples the front end from the back end.
module jse_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  jse_pkg::queue_wr_t wr,
	input  logic               pop,
	output logic               full,
	output jse_pkg::queue_rd_t rd
);

	localparam int unsigned AW = jse_pkg::QUEUE_AW;

	jse_pkg::desc_t entry_q [jse_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_pop;

	assign full         = (count_q == (AW + 1)'(jse_pkg::QUEUE_DEPTH));
	assign rd.not_empty = (count_q != '0);
	assign rd.desc      = entry_q[rd_ptr_q];
	assign do_pop       = pop && rd.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) begin
			entry_q[wr_ptr_q] <= wr.desc;
		end
	end

endmodule

/* src/jse_back.sv */
`timescale 1ns / 1ps
// Back end: walks each descriptor one output byte per cycle, while the output is not stalled, into an output register.
module jse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jse_pkg::queue_rd_t rd,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,  // [7:0] out_byte
	output logic               m_axis_tlast   // end_of_run
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic       load;
	logic       run_done;

	assign load     = rd.not_empty && (!out_valid_q || m_axis_tready);
	assign run_done = ({1'b0, idx_q} == jse_pkg::run_len(rd.desc) - 4'd1);
	assign pop      = load && run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= run_done ? 3'd0 : idx_q + 3'd1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= jse_pkg::run_byte(rd.desc, idx_q);
			out_last_q <= run_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* src/json_string_escaper.sv */
`timescale 1ns / 1ps
// Top level of the streaming JSON string escaper: front end, descriptor queue and back end.
// An item's descriptor is registered in the queue, and each of its output bytes in the output register.
// An item gives from 1 to 8 output bytes; the back end sends one byte per cycle while the output is
// not stalled, and the four-entry queue absorbs bursts of escapes.
// Input is accepted whenever the queue has room, even while the output is stalled.
// Reset (arst_n low) empties the queue and the output register at once.
module json_string_escaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] text_byte
	input  logic       s_axis_tlast,  // last_of_string
	input  logic [1:0] s_axis_tuser,  // [0] first_of_string, [1] empty_string
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast   // end_of_run
);

	// The front end turns each item into a small descriptor: whether quotes
	// open and close it, and whether its byte passes plainly, takes a
	// backslash pair, or becomes a six-byte unicode escape.
	jse_pkg::queue_wr_t q_wr;
	jse_pkg::queue_rd_t q_rd;
	logic               q_full;
	logic               q_pop;

	jse_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (q_full),
		.wr            (q_wr)
	);

	// The queue lets the input keep flowing while the back end is busy
	// spelling out a long escape or the output side is stalled.
	jse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.rd     (q_rd)
	);

	// The back end steps through the descriptor at the head of the queue,
	// one output byte per cycle while the output is not stalled, marking the
	// final byte of each item with tlast, and releases the descriptor when that byte is loaded.
	jse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd            (q_rd),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
